// File: rtl/fixed_point_to_decimal_ascii_core_defines.svh
// Assertion helpers shared by the RTL.
`ifndef FIXED_POINT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define FIXED_POINT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication.
`define FPDA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FPDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fpda_pkg.sv
package fpda_pkg;

    localparam int C_MAX_FRAC_DIGITS = 8;
    localparam int C_NDIG_W          = $clog2(C_MAX_FRAC_DIGITS + 1);
    localparam int C_QUEUE_DEPTH     = 2;
    localparam int C_QPTR_W          = (C_QUEUE_DEPTH > 1) ? $clog2(C_QUEUE_DEPTH) : 1;
    localparam int C_QCNT_W          = $clog2(C_QUEUE_DEPTH + 1);

    localparam logic [3:0] C_FD_RESET   = 4'd2;
    localparam logic [6:0] C_CHAR_ZERO  = 7'h30;
    localparam logic [6:0] C_CHAR_NINE  = 7'h39;
    localparam logic [6:0] C_CHAR_DOT   = 7'h2E;
    localparam logic [6:0] C_CHAR_MINUS = 7'h2D;

    localparam logic [1:0] C_LEN_ONE   = 2'd1;
    localparam logic [1:0] C_LEN_TWO   = 2'd2;
    localparam logic [1:0] C_LEN_THREE = 2'd3;

    typedef struct packed {
        logic                neg;
        logic                hund;
        logic [3:0]          tens;
        logic [3:0]          ones;
        logic [1:0]          int_len;
        logic [7:0]          frac;
        logic [C_NDIG_W-1:0] ndig;
    } t_desc;

endpackage

// File: rtl/fpda_front.sv
module fpda_front import fpda_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_fraction_digits,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_value,
    input  logic        i_full,
    output logic        o_push,
    output t_desc       o_desc
);

    logic [3:0]  r_fraction_digits;
    logic        neg;
    logic [16:0] mag;
    logic [7:0]  ipart;
    logic        hund;
    logic [6:0]  rem;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  tens10;
    logic [6:0]  ones_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fraction_digits <= C_FD_RESET;
        end else if (i_cfg_valid) begin
            r_fraction_digits <= i_cfg_fraction_digits;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        neg       = i_value[15];
        mag       = neg ? (17'h10000 - {1'b0, i_value}) : {1'b0, i_value};
        ipart     = mag[15:8];
        hund      = (ipart >= 8'd100);
        rem       = hund ? 7'(ipart - 8'd100) : ipart[6:0];
        tens_prod = {8'd0, rem} * 15'd205;
        tens      = tens_prod[14:11];
        tens10    = {tens, 3'b000} + {2'b00, tens, 1'b0};
        ones_full = rem - tens10;

        o_desc.neg  = neg;
        o_desc.hund = hund;
        o_desc.tens = tens;
        o_desc.ones = ones_full[3:0];
        o_desc.frac = mag[7:0];
        if (hund) begin
            o_desc.int_len = C_LEN_THREE;
        end else if (ipart >= 8'd10) begin
            o_desc.int_len = C_LEN_TWO;
        end else begin
            o_desc.int_len = C_LEN_ONE;
        end
        if (int'(r_fraction_digits) > C_MAX_FRAC_DIGITS) begin
            o_desc.ndig = C_NDIG_W'(C_MAX_FRAC_DIGITS);
        end else begin
            o_desc.ndig = C_NDIG_W'(r_fraction_digits);
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// File: rtl/fpda_queue.sv
`include "fixed_point_to_decimal_ascii_core_defines.svh"

module fpda_queue import fpda_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_desc
);

    t_desc               r_mem [C_QUEUE_DEPTH];
    logic [C_QPTR_W-1:0] r_wr;
    logic [C_QPTR_W-1:0] r_rd;
    logic [C_QCNT_W-1:0] r_count;
    logic [C_QCNT_W-1:0] n_count;

    assign o_full  = (r_count == C_QCNT_W'(C_QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= (int'(r_wr) == C_QUEUE_DEPTH - 1) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (int'(r_rd) == C_QUEUE_DEPTH - 1) ? '0 : r_rd + 1'b1;
            end
        end
    end

    `FPDA_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= C_QCNT_W'(C_QUEUE_DEPTH), "queue count exceeds depth")
    `FPDA_ASSERT_NEXT(a_count_grow, i_clk, i_rst_n, i_push && !i_pop,
        r_count == $past(r_count) + 1'b1, "queue count did not advance on push")

endmodule

// File: rtl/fpda_back.sv
`include "fixed_point_to_decimal_ascii_core_defines.svh"

module fpda_back import fpda_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_desc      i_q_desc,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_ascii_char,
    output logic       o_last
);

    localparam logic [2:0] PH_SIGN = 3'd0;
    localparam logic [2:0] PH_HUND = 3'd1;
    localparam logic [2:0] PH_TENS = 3'd2;
    localparam logic [2:0] PH_ONES = 3'd3;
    localparam logic [2:0] PH_DOT  = 3'd4;
    localparam logic [2:0] PH_FRAC = 3'd5;

    logic                r_busy;
    logic [2:0]          r_phase;
    t_desc               r_desc;
    logic [7:0]          r_frac;
    logic [C_NDIG_W-1:0] r_cnt;
    logic                r_out_valid;
    logic [6:0]          r_char;
    logic                r_last;

    logic                slot_free;
    logic                emit;
    logic                finish;
    logic                load;
    logic [6:0]          ch;
    logic                lst;
    logic [2:0]          n_phase;
    logic [2:0]          start_phase;
    logic [11:0]         frac10;
    logic [7:0]          n_frac;
    logic [C_NDIG_W-1:0] n_cnt;

    always_comb begin
        case (i_q_desc.int_len)
            C_LEN_THREE: start_phase = PH_HUND;
            C_LEN_TWO:   start_phase = PH_TENS;
            default:     start_phase = PH_ONES;
        endcase
        if (i_q_desc.neg) begin
            start_phase = PH_SIGN;
        end
    end

    always_comb begin
        frac10  = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0};
        ch      = C_CHAR_ZERO;
        lst     = 1'b0;
        n_phase = r_phase;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        case (r_phase)
            PH_SIGN: begin
                ch = C_CHAR_MINUS;
                case (r_desc.int_len)
                    C_LEN_THREE: n_phase = PH_HUND;
                    C_LEN_TWO:   n_phase = PH_TENS;
                    default:     n_phase = PH_ONES;
                endcase
            end
            PH_HUND: begin
                ch      = C_CHAR_ZERO + {6'd0, r_desc.hund};
                n_phase = PH_TENS;
            end
            PH_TENS: begin
                ch      = C_CHAR_ZERO + {3'd0, r_desc.tens};
                n_phase = PH_ONES;
            end
            PH_ONES: begin
                ch      = C_CHAR_ZERO + {3'd0, r_desc.ones};
                n_phase = PH_DOT;
            end
            PH_DOT: begin
                ch      = C_CHAR_DOT;
                lst     = (r_cnt == '0);
                n_phase = PH_FRAC;
            end
            PH_FRAC: begin
                ch     = C_CHAR_ZERO + {3'd0, frac10[11:8]};
                lst    = (r_cnt == C_NDIG_W'(1));
                n_frac = frac10[7:0];
                n_cnt  = r_cnt - 1'b1;
            end
            default: begin
                ch = C_CHAR_ZERO;
            end
        endcase
    end

    assign slot_free = !r_out_valid || i_ready;
    assign emit      = r_busy && slot_free;
    assign finish    = emit && lst;
    assign load      = i_q_valid && (!r_busy || finish);
    assign o_q_pop   = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_SIGN;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy  <= 1'b1;
                r_phase <= start_phase;
            end else if (finish) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_phase <= n_phase;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_desc <= i_q_desc;
            r_frac <= i_q_desc.frac;
            r_cnt  <= i_q_desc.ndig;
        end else if (emit) begin
            r_frac <= n_frac;
            r_cnt  <= n_cnt;
        end
        if (emit) begin
            r_char <= ch;
            r_last <= lst;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ascii_char = r_char;
    assign o_last       = r_last;

    `FPDA_ASSERT_IMPL(a_frac_count, i_clk, i_rst_n, r_busy && (r_phase == PH_FRAC),
        r_cnt != '0, "fraction phase with no digits left")
    `FPDA_ASSERT_IMPL(a_char_set, i_clk, i_rst_n, r_out_valid,
        (r_char == C_CHAR_MINUS) || (r_char == C_CHAR_DOT) ||
        ((r_char >= C_CHAR_ZERO) && (r_char <= C_CHAR_NINE)), "illegal output character")
    `FPDA_ASSERT_IMPL(a_last_char, i_clk, i_rst_n, r_out_valid && r_last,
        r_char != C_CHAR_MINUS, "sign marked as last character")

endmodule

// File: rtl/fixed_point_to_decimal_ascii_core.sv
// Channel  Handshake                     Payload
// cfg      i_cfg_valid / o_cfg_ready     i_cfg_fraction_digits[3:0]
// in       i_valid / o_ready             i_value[15:0] signed 8.8
// out      o_valid / i_ready             o_ascii_char[6:0], o_last
//
// One character leaves per cycle while i_ready is held; a number takes 2 to 13 characters.
// The output register sets the rate; a queued next number loads in the same cycle as a last.
// Inputs are classified combinationally into a two-word queue; o_ready drops when full.
// Synchronous active-low reset; fraction_digits resets to 2, values above 8 act as 8.
// A stalled output holds the back end; the front keeps filling the queue.
module fixed_point_to_decimal_ascii_core import fpda_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_fraction_digits,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_ascii_char,
    output logic        o_last
);

    t_desc front_desc;
    t_desc queue_desc;
    logic  push;
    logic  full;
    logic  pop;
    logic  queue_valid;

    fpda_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_fraction_digits (i_cfg_fraction_digits),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_value               (i_value),
        .i_full                (full),
        .o_push                (push),
        .o_desc                (front_desc)
    );

    fpda_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_desc  (queue_desc)
    );

    fpda_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (queue_valid),
        .i_q_desc     (queue_desc),
        .o_q_pop      (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

endmodule
